### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sfrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfrm_pkg;

   // default geometry
   localparam int DEF_FRAMES  = 256;
   localparam int DEF_SHARERS = 8;

   // field widths
   localparam int KIND_W   = 2;
   localparam int FRAME_W  = 16;
   localparam int PROC_W   = 8;
   localparam int PAGE_W   = 52;
   localparam int LIMIT_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;
   localparam int ENTRY_W  = PROC_W + PAGE_W;

   // most results one collect may produce
   localparam int MAX_LIST = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD     = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_QUERY   = 2'd2,
      KIND_COLLECT = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_COUNT,
      S_SCAN,
      S_FINISH,
      S_EMIT,
      S_LIST,
      S_LDATA
   } state_type;

endpackage

`default_nettype wire

### hdl/sfrm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfrm_req_if;
   import sfrm_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [FRAME_W-1:0]  frame;
   logic [PROC_W-1:0]   process_id;
   logic [PAGE_W-1:0]   vpage;
   logic [LIMIT_W-1:0]  list_limit;

   modport source (
      output valid, kind, frame, process_id, vpage, list_limit,
      input  ready
   );

   modport sink (
      input  valid, kind, frame, process_id, vpage, list_limit,
      output ready
   );

endinterface

`default_nettype wire

### hdl/sfrm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfrm_rsp_if;
   import sfrm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                present;
   logic [COUNT_W-1:0]  sharer_count;
   logic                listed_valid;
   logic [PROC_W-1:0]   listed_process;
   logic [PAGE_W-1:0]   listed_page;
   logic                last;

   modport source (
      output valid, status, present, sharer_count, listed_valid, listed_process,
             listed_page, last,
      input  ready
   );

   modport sink (
      input  valid, status, present, sharer_count, listed_valid, listed_process,
             listed_page, last,
      output ready
   );

endinterface

`default_nettype wire

### hdl/sfrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sfrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/shared_frame_reverse_map.sv
// Reverse page-mapping table: for each physical frame it keeps an ordered list of up to
// SHARERS sharers (process id and virtual page), oldest in the lowest slot. Add appends a
// sharer as the newest unless it is already there or the frame is full; remove deletes it
// and closes the gap; query reports presence and the count; collect lists the sharers
// newest-first, one result item each, up to the limit (at most 8). Sharers live in one
// memory of FRAMES*SHARERS entries and the counts in a memory of FRAMES entries; both have
// one write and one read port and a registered read. After reset the block clears every
// entry of the count memory, one after another, and takes no item until that pass is done.
// Add, remove and query walk the sharer memory one entry a cycle to find the match (remove
// moves later entries down during the same walk); a frame out of range is answered
// without a memory access. Collect reads each listed sharer from memory before loading
// its result, and waits while the result side is busy. One item is worked on at a time;
// the next one is taken while the last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module shared_frame_reverse_map #(
   parameter int FRAMES  = sfrm_pkg::DEF_FRAMES,
   parameter int SHARERS = sfrm_pkg::DEF_SHARERS
) (
   input  logic       clock,
   input  logic       reset,
   sfrm_req_if.sink   req_ch,
   sfrm_rsp_if.source rsp_ch
);
   import sfrm_pkg::*;

   localparam int STORE_DEPTH = FRAMES * SHARERS;
   localparam int FRAME_AW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(SHARERS + 1);
   localparam int COUNT_MAX   = (2 ** COUNT_W) - 1;

   localparam logic [FRAME_W:0]    FRAME_LIMIT = (FRAME_W + 1)'(FRAMES);
   localparam logic [FRAME_AW-1:0] CLR_LAST    = FRAME_AW'(FRAMES - 1);
   localparam logic [STORE_AW-1:0] ROW_SIZE    = STORE_AW'(SHARERS);
   localparam logic [CNT_W-1:0]    CNT_FULL    = CNT_W'(SHARERS);
   localparam logic [CNT_W-1:0]    CNT_ONE     = CNT_W'(1);
   localparam logic [LIMIT_W-1:0]  LIMIT_CAP   = LIMIT_W'(MAX_LIST);

   // control and item state
   state_type               state_ff, state_in;
   logic [FRAME_AW-1:0]     clr_ff, clr_in;
   kind_type                kind_ff, kind_in;
   logic [FRAME_AW-1:0]     frame_idx_ff, frame_idx_in;
   logic [STORE_AW-1:0]     base_ff, base_in;
   logic [PROC_W-1:0]       proc_ff, proc_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        m_ff, m_in;
   logic                    found_ff, found_in;
   logic                    present_ff, present_in;
   status_type              status_ff, status_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_listed_ff, rsp_listed_in;
   logic [PROC_W-1:0]       rsp_proc_ff, rsp_proc_in;
   logic [PAGE_W-1:0]       rsp_page_ff, rsp_page_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memory ports
   logic                    cnt_we, cnt_re;
   logic [FRAME_AW-1:0]     cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]        cnt_wdata, cnt_rd;
   logic                    st_we, st_re;
   logic [STORE_AW-1:0]     st_waddr, st_raddr;
   logic [ENTRY_W-1:0]      st_wdata, ent_rd;

   // derived terms
   logic                    req_range;
   logic                    out_free;
   logic                    last_scan;
   logic                    match;
   logic [CNT_W-1:0]        n_clamp;
   logic [LIMIT_W-1:0]      lim_cap;
   logic [CNT_W-1:0]        m_calc;
   logic [COUNT_W-1:0]      count_sat;

   sfrm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (FRAMES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   sfrm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (ent_rd)
   );

   // shared decode terms
   assign req_range = ({1'b0, req_ch.frame} >= FRAME_LIMIT);
   assign out_free  = ~rsp_valid_ff | rsp_ch.ready;
   assign last_scan = (idx_ff == (n_ff - CNT_ONE));
   assign match     = (ent_rd == {proc_ff, page_ff});
   assign n_clamp   = (int'(cnt_rd) > SHARERS) ? CNT_FULL : cnt_rd;
   assign lim_cap   = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign m_calc    = (int'(lim_cap) < int'(n_clamp)) ? CNT_W'(lim_cap) : n_clamp;
   assign count_sat = (int'(n_ff) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(n_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = req_range ? S_EMIT : S_COUNT;
            end
         end
         S_COUNT: begin
            if (kind_ff == KIND_COLLECT) begin
               state_in = (m_calc == '0) ? S_EMIT : S_LIST;
            end else begin
               state_in = (n_clamp == '0) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            if (last_scan) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_LIST: state_in = S_LDATA;
         S_LDATA: begin
            if (out_free) begin
               state_in = ((idx_ff + CNT_ONE) == m_ff) ? S_IDLE : S_LIST;
            end
         end
      endcase
   end

   // datapath, memory control and result loading
   always_comb begin
      clr_in         = clr_ff;
      kind_in        = kind_ff;
      frame_idx_in   = frame_idx_ff;
      base_in        = base_ff;
      proc_in        = proc_ff;
      page_in        = page_ff;
      limit_in       = limit_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      m_in           = m_ff;
      found_in       = found_ff;
      present_in     = present_ff;
      status_in      = status_ff;

      rsp_valid_in   = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_listed_in  = rsp_listed_ff;
      rsp_proc_in    = rsp_proc_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_last_in    = rsp_last_ff;

      cnt_we         = 1'b0;
      cnt_waddr      = frame_idx_ff;
      cnt_wdata      = n_ff;
      cnt_re         = 1'b0;
      cnt_raddr      = req_ch.frame[FRAME_AW-1:0];
      st_we          = 1'b0;
      st_waddr       = base_ff;
      st_wdata       = {proc_ff, page_ff};
      st_re          = 1'b0;
      st_raddr       = base_ff;

      unique case (state_ff)
         // zero one count per cycle
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            clr_in    = clr_ff + FRAME_AW'(1);
         end
         // take the item and fetch its frame's count
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in      = kind_type'(req_ch.kind);
               frame_idx_in = req_ch.frame[FRAME_AW-1:0];
               base_in      = STORE_AW'(req_ch.frame[FRAME_AW-1:0]) * ROW_SIZE;
               proc_in      = req_ch.process_id;
               page_in      = req_ch.vpage;
               limit_in     = req_ch.list_limit;
               present_in   = 1'b0;
               if (req_range) begin
                  status_in = ST_RANGE;
                  n_in      = '0;
               end else begin
                  cnt_re    = 1'b1;
               end
            end
         end
         // latch the count and set up the row walk, or the list for collect
         S_COUNT: begin
            n_in       = n_clamp;
            idx_in     = '0;
            found_in   = 1'b0;
            present_in = 1'b0;
            status_in  = ST_OK;
            m_in       = m_calc;
            st_re      = 1'b1;
            st_raddr   = base_ff;
         end
         // compare one entry, shift down behind a match on remove
         S_SCAN: begin
            found_in = found_ff | match;
            if (found_ff && (kind_ff == KIND_REMOVE)) begin
               st_we    = 1'b1;
               st_waddr = base_ff + STORE_AW'(idx_ff) - STORE_AW'(1);
               st_wdata = ent_rd;
            end
            if (!last_scan) begin
               st_re    = 1'b1;
               st_raddr = base_ff + STORE_AW'(idx_ff + CNT_ONE);
            end
            idx_in = idx_ff + CNT_ONE;
         end
         // commit the row update and the new count
         S_FINISH: begin
            unique case (kind_ff)
               KIND_ADD: begin
                  if (found_ff) begin
                     status_in = ST_OK;
                  end else if (n_ff == CNT_FULL) begin
                     status_in = ST_FULL;
                  end else begin
                     st_we     = 1'b1;
                     st_waddr  = base_ff + STORE_AW'(n_ff);
                     cnt_we    = 1'b1;
                     cnt_wdata = n_ff + CNT_ONE;
                     n_in      = n_ff + CNT_ONE;
                     status_in = ST_OK;
                  end
               end
               KIND_REMOVE: begin
                  if (found_ff) begin
                     cnt_we    = 1'b1;
                     cnt_wdata = n_ff - CNT_ONE;
                     n_in      = n_ff - CNT_ONE;
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               KIND_QUERY: begin
                  present_in = found_ff;
                  status_in  = ST_OK;
               end
               KIND_COLLECT: begin
                  status_in = ST_OK;
               end
            endcase
         end
         // load the single result of the item
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_present_in = present_ff;
               rsp_count_in   = count_sat;
               rsp_listed_in  = 1'b0;
               rsp_proc_in    = '0;
               rsp_page_in    = '0;
               rsp_last_in    = 1'b1;
            end
         end
         // fetch the next sharer, newest first
         S_LIST: begin
            st_re    = 1'b1;
            st_raddr = base_ff + STORE_AW'(n_ff - CNT_ONE - idx_ff);
         end
         // load one listed sharer
         S_LDATA: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_present_in = 1'b0;
               rsp_count_in   = count_sat;
               rsp_listed_in  = 1'b1;
               rsp_proc_in    = ent_rd[ENTRY_W-1:PAGE_W];
               rsp_page_in    = ent_rd[PAGE_W-1:0];
               rsp_last_in    = ((idx_ff + CNT_ONE) == m_ff);
               idx_in         = idx_ff + CNT_ONE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      frame_idx_ff   <= frame_idx_in;
      base_ff        <= base_in;
      proc_ff        <= proc_in;
      page_ff        <= page_in;
      limit_ff       <= limit_in;
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      m_ff           <= m_in;
      found_ff       <= found_in;
      present_ff     <= present_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_listed_ff  <= rsp_listed_in;
      rsp_proc_ff    <= rsp_proc_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // drive the channels
   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.present        = rsp_present_ff;
   assign rsp_ch.sharer_count   = rsp_count_ff;
   assign rsp_ch.listed_valid   = rsp_listed_ff;
   assign rsp_ch.listed_process = rsp_proc_ff;
   assign rsp_ch.listed_page    = rsp_page_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

`default_nettype wire

### hdl/sfrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfrm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sfrm_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_present,
   input logic [sfrm_pkg::COUNT_W-1:0]  rsp_sharer_count,
   input logic                          rsp_listed_valid,
   input logic                          rsp_last
);
   import sfrm_pkg::*;

   logic req_take;
   logic rsp_stall;
   logic range_rsp;
   logic range_shape;
   logic listed_rsp;
   logic listed_shape;

   // handshake and result shape terms
   assign req_take     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign range_rsp    = rsp_valid && (rsp_status == ST_RANGE);
   assign range_shape  = rsp_last && !rsp_listed_valid && !rsp_present
                         && (rsp_sharer_count == '0);
   assign listed_rsp   = rsp_valid && rsp_listed_valid;
   assign listed_shape = (rsp_status == ST_OK) && !rsp_present && (rsp_sharer_count != '0);

   // a waiting item stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "rsp item dropped while stalled")

   // one item at a time: the block is busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, !req_ready, "req taken twice in a row")

   // a range error is a lone empty result
   `ASSERT_SYNC(a_range_result, clock, reset, !range_rsp || range_shape, "bad range error result")

   // a listed sharer comes from a successful collect of a non-empty frame
   `ASSERT_SYNC(a_listed_result, clock, reset, !listed_rsp || listed_shape, "bad listed result")

endmodule

bind shared_frame_reverse_map sfrm_checker u_sfrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_present      (rsp_ch.present),
   .rsp_sharer_count (rsp_ch.sharer_count),
   .rsp_listed_valid (rsp_ch.listed_valid),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire

### bench/sharer_map_checker.sv
`timescale 1ns / 1ps

// Watch both channels, keep a shadow copy of the sharer table and compare every reply.
module sharer_map_checker import sfrm_pkg::*; #(
   parameter int FRAMES  = DEF_FRAMES,
   parameter int SHARERS = DEF_SHARERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [FRAME_W-1:0]  req_frame,
   input  logic [PROC_W-1:0]   req_process_id,
   input  logic [PAGE_W-1:0]   req_vpage,
   input  logic [LIMIT_W-1:0]  req_list_limit,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_present,
   input  logic [COUNT_W-1:0]  rsp_sharer_count,
   input  logic                rsp_listed_valid,
   input  logic [PROC_W-1:0]   rsp_listed_process,
   input  logic [PAGE_W-1:0]   rsp_listed_page,
   input  logic                rsp_last,
   output int                  mismatch_count,
   output int                  replies_pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                present;
      logic [COUNT_W-1:0]  sharer_count;
      logic                listed_valid;
      logic [PROC_W-1:0]   listed_process;
      logic [PAGE_W-1:0]   listed_page;
      logic                last;
   } sharer_reply_type;

   // shadow table: slot 0 is the oldest sharer of a frame
   logic [PROC_W-1:0] shadow_pid  [FRAMES][SHARERS];
   logic [PAGE_W-1:0] shadow_page [FRAMES][SHARERS];
   int                shadow_fill [FRAMES];

   sharer_reply_type replies_due[$];
   int               errors = 0;

   initial begin
      mismatch_count  = 0;
      replies_pending = 0;
   end

   // Apply one request to the shadow table and queue the replies it causes.
   task automatic apply_to_sharer_table(input kind_type kind, input logic [FRAME_W-1:0] frame,
                                        input logic [PROC_W-1:0] pid,
                                        input logic [PAGE_W-1:0] page,
                                        input logic [LIMIT_W-1:0] limit);
      sharer_reply_type reply;
      int               fill;
      int               slot;
      int               shown;
      reply      = '0;
      reply.last = 1'b1;
      if (frame >= FRAMES) begin
         reply.status = ST_RANGE;
         replies_due.push_back(reply);
         return;
      end
      fill = shadow_fill[frame];
      slot = -1;
      for (int i = 0; i < fill; i++) begin
         if (slot < 0 && shadow_pid[frame][i] == pid && shadow_page[frame][i] == page)
            slot = i;
      end
      shown = 0;
      reply.status = ST_OK;
      case (kind)
         KIND_ADD: begin
            if (slot < 0) begin
               if (fill >= SHARERS) begin
                  reply.status = ST_FULL;
               end else begin
                  shadow_pid[frame][fill]  = pid;
                  shadow_page[frame][fill] = page;
                  fill++;
               end
            end
         end
         KIND_REMOVE: begin
            if (slot < 0) begin
               reply.status = ST_NOT_FOUND;
            end else begin
               // close the gap, keeping the order of the rest
               for (int i = slot; i + 1 < fill; i++) begin
                  shadow_pid[frame][i]  = shadow_pid[frame][i+1];
                  shadow_page[frame][i] = shadow_page[frame][i+1];
               end
               fill--;
            end
         end
         KIND_QUERY: begin
            reply.present = (slot >= 0);
         end
         default: begin
            shown = int'(limit);
            if (shown > MAX_LIST) shown = MAX_LIST;
            if (shown > fill) shown = fill;
         end
      endcase
      shadow_fill[frame]  = fill;
      reply.sharer_count  = (fill > 15) ? 4'd15 : fill[COUNT_W-1:0];
      if (shown == 0) begin
         replies_due.push_back(reply);
      end else begin
         // newest sharer first
         for (int i = 0; i < shown; i++) begin
            reply.listed_valid   = 1'b1;
            reply.listed_process = shadow_pid[frame][fill-1-i];
            reply.listed_page    = shadow_page[frame][fill-1-i];
            reply.last           = (i + 1 == shown);
            replies_due.push_back(reply);
         end
      end
   endtask

   always @(posedge clock) begin
      sharer_reply_type seen;
      sharer_reply_type want;
      if (reset) begin
         for (int f = 0; f < FRAMES; f++) shadow_fill[f] = 0;
         replies_due.delete();
      end else begin
         // check the reply first: it can only belong to an earlier request
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_status, rsp_present, rsp_sharer_count, rsp_listed_valid,
                     rsp_listed_process, rsp_listed_page, rsp_last};
            if (replies_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t reply with none awaited: st=%0d pr=%0d cnt=%0d lv=%0d pid=%0h pg=%0h last=%0d",
                           $realtime, seen.status, seen.present, seen.sharer_count,
                           seen.listed_valid, seen.listed_process, seen.listed_page, seen.last);
            end else begin
               want = replies_due.pop_front();
               if (seen.status !== want.status || seen.present !== want.present ||
                   seen.sharer_count !== want.sharer_count ||
                   seen.listed_valid !== want.listed_valid ||
                   seen.listed_process !== want.listed_process ||
                   seen.listed_page !== want.listed_page || seen.last !== want.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%t reply differs, expected: st=%0d pr=%0d cnt=%0d lv=%0d pid=%0h pg=%0h last=%0d",
                              $realtime, want.status, want.present, want.sharer_count,
                              want.listed_valid, want.listed_process, want.listed_page,
                              want.last);
                     $display("%t                 actual: st=%0d pr=%0d cnt=%0d lv=%0d pid=%0h pg=%0h last=%0d",
                              $realtime, seen.status, seen.present, seen.sharer_count,
                              seen.listed_valid, seen.listed_process, seen.listed_page,
                              seen.last);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            apply_to_sharer_table(kind_type'(req_kind), req_frame, req_process_id,
                                  req_vpage, req_list_limit);
      end
      mismatch_count  <= errors;
      replies_pending <= replies_due.size();
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sfrm_pkg::*;

   localparam int FRAMES  = DEF_FRAMES;
   localparam int SHARERS = DEF_SHARERS;
   localparam int RANDOM_ITEMS = 310;
   localparam int PAUSE_AT     = 150;
   localparam int QUIET_FROM   = 250;
   localparam int POOL_SIZE    = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfrm_req_if req_ch ();
   sfrm_rsp_if rsp_ch ();

   int mismatch_count;
   int replies_pending;

   logic rsp_take   = 1'b0;
   logic quiet_tail = 1'b0;
   int   hold_left  = 0;
   int   flow_left  = 0;

   // sharer pool: a few repeated pairs so that removes and queries hit
   logic [PROC_W-1:0] pool_pid  [POOL_SIZE];
   logic [PAGE_W-1:0] pool_page [POOL_SIZE];
   logic [FRAME_W-1:0] hot_frame [4];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   shared_frame_reverse_map #(
      .FRAMES  (FRAMES),
      .SHARERS (SHARERS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sharer_map_checker #(
      .FRAMES  (FRAMES),
      .SHARERS (SHARERS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_kind           (req_ch.kind),
      .req_frame          (req_ch.frame),
      .req_process_id     (req_ch.process_id),
      .req_vpage          (req_ch.vpage),
      .req_list_limit     (req_ch.list_limit),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_status         (rsp_ch.status),
      .rsp_present        (rsp_ch.present),
      .rsp_sharer_count   (rsp_ch.sharer_count),
      .rsp_listed_valid   (rsp_ch.listed_valid),
      .rsp_listed_process (rsp_ch.listed_process),
      .rsp_listed_page    (rsp_ch.listed_page),
      .rsp_last           (rsp_ch.last),
      .mismatch_count     (mismatch_count),
      .replies_pending    (replies_pending)
   );

   assign rsp_ch.ready = rsp_take;

   // Stall the reply side in random bursts; take every reply in the quiet tail.
   always @(posedge clock) begin
      if (quiet_tail) begin
         rsp_take <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_take  <= 1'b0;
      end else if (flow_left != 0) begin
         flow_left <= flow_left - 1;
         rsp_take  <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         hold_left <= $urandom_range(0, 9);
         rsp_take  <= 1'b0;
      end else begin
         flow_left <= $urandom_range(0, 24);
         rsp_take  <= 1'b1;
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input kind_type kind, input logic [FRAME_W-1:0] frame,
                               input logic [PROC_W-1:0] pid, input logic [PAGE_W-1:0] page,
                               input logic [LIMIT_W-1:0] limit);
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.frame        <= frame;
      req_ch.process_id   <= pid;
      req_ch.vpage        <= page;
      req_ch.list_limit   <= limit;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_pooled(input kind_type kind, input logic [FRAME_W-1:0] frame,
                              input int entry, input logic [LIMIT_W-1:0] limit);
      send_request(kind, frame, pool_pid[entry], pool_page[entry], limit);
   endtask

   initial begin
      logic [63:0]        wide;
      logic [FRAME_W-1:0] frame;
      logic [PROC_W-1:0]  pid;
      logic [PAGE_W-1:0]  page;
      logic [LIMIT_W-1:0] limit;
      kind_type           kind;
      int                 pick;
      int                 entry;
      int                 waited;

      req_ch.valid        <= 1'b0;
      req_ch.kind         <= KIND_ADD;
      req_ch.frame        <= '0;
      req_ch.process_id   <= '0;
      req_ch.vpage        <= '0;
      req_ch.list_limit   <= '0;

      // pool with extremes, a shared pid and a shared page
      for (int i = 0; i < POOL_SIZE; i++) begin
         wide         = {$urandom(), $urandom()};
         pool_pid[i]  = PROC_W'($urandom_range(0, 255));
         pool_page[i] = wide[PAGE_W-1:0];
      end
      pool_pid[0]  = '0;
      pool_page[0] = '0;
      pool_pid[1]  = '1;
      pool_page[1] = '1;
      pool_pid[3]  = pool_pid[2];
      pool_page[5] = pool_page[4];
      hot_frame[0] = 16'd0;
      hot_frame[1] = 16'd1;
      hot_frame[2] = FRAME_W'(FRAMES - 1);
      hot_frame[3] = FRAME_W'($urandom_range(2, FRAMES - 2));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: range errors and an empty collect
      send_pooled(KIND_QUERY, FRAME_W'(FRAMES), 0, 4'd0);
      send_pooled(KIND_COLLECT, 16'hFFFF, 1, 4'hF);
      send_pooled(KIND_COLLECT, 16'd0, 0, 4'd8);
      // directed: add, duplicate add, query hit and miss, collects and removes on frame 0
      send_pooled(KIND_ADD, 16'd0, 0, 4'd0);
      send_pooled(KIND_ADD, 16'd0, 1, 4'hF);
      send_pooled(KIND_ADD, 16'd0, 1, 4'd0);
      send_pooled(KIND_QUERY, 16'd0, 0, 4'd0);
      send_pooled(KIND_QUERY, 16'd0, 2, 4'd0);
      send_pooled(KIND_COLLECT, 16'd0, 0, 4'd0);
      send_pooled(KIND_COLLECT, 16'd0, 0, 4'hF);
      send_pooled(KIND_REMOVE, 16'd0, 2, 4'd0);
      send_pooled(KIND_REMOVE, 16'd0, 0, 4'd0);
      send_pooled(KIND_COLLECT, 16'd0, 0, 4'd8);
      // directed: fill the top frame past capacity, then list and remove from the middle
      for (int i = 0; i <= SHARERS; i++)
         send_pooled(KIND_ADD, FRAME_W'(FRAMES - 1), i, 4'd0);
      send_pooled(KIND_COLLECT, FRAME_W'(FRAMES - 1), 0, 4'd8);
      send_pooled(KIND_REMOVE, FRAME_W'(FRAMES - 1), 4, 4'd0);
      send_pooled(KIND_COLLECT, FRAME_W'(FRAMES - 1), 0, 4'd3);

      // random: mostly pooled sharers on a few hot frames
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (replies_pending != 0);
         end else if (n >= QUIET_FROM) begin
            quiet_tail <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         entry = $urandom_range(0, POOL_SIZE - 1);
         pid   = pool_pid[entry];
         page  = pool_page[entry];
         if ($urandom_range(0, 6) == 0) begin
            wide = {$urandom(), $urandom()};
            pid  = PROC_W'($urandom_range(0, 255));
            page = wide[PAGE_W-1:0];
         end
         frame = hot_frame[$urandom_range(0, 3)];
         if ($urandom_range(0, 9) == 0) frame = FRAME_W'($urandom_range(0, FRAMES - 1));
         limit = LIMIT_W'($urandom_range(0, 15));
         pick  = $urandom_range(0, 99);
         if (pick < 5) begin
            frame = FRAME_W'($urandom_range(FRAMES, 65535));
            kind  = kind_type'($urandom_range(0, 3));
         end else if (pick < 42) begin
            kind = KIND_ADD;
         end else if (pick < 62) begin
            kind = KIND_REMOVE;
         end else if (pick < 80) begin
            kind = KIND_QUERY;
         end else begin
            kind = KIND_COLLECT;
         end
         send_request(kind, frame, pid, page, limit);
      end
      req_ch.valid <= 1'b0;

      // drain, then allow a few more cycles for stray replies
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (replies_pending != 0 && waited < 5000);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Give up if the run hangs.
   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
